// File: design/ismc_pkg.sv
// ismc_pkg: shared types and constants for the interrupt status/mask controller.
// Holds operation codes, register indexes, window decode constants and the
// request/result structs. No dependencies.
`timescale 1ns / 1ps

package ismc_pkg;

   localparam logic [31:0] WINDOW_BASE        = 32'd532518912;
   localparam logic [31:0] WINDOW_BYTES       = 32'd32;
   localparam int          STRIDE_SHIFT       = 2;   // register stride of 4 bytes
   localparam int          BYTE_SHIFT         = 24;
   localparam logic [7:0]  LINE2_MAPPED_CAUSE = 8'd128;
   localparam logic [7:0]  LINE3_MAPPED_CAUSE = 8'd8;
   localparam int          REG_COUNT          = 8;

   typedef enum logic [1:0] {
      OP_READ   = 2'd0,
      OP_WRITE  = 2'd1,
      OP_ASSERT = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      GRP_LOCAL0 = 2'd0,
      GRP_LOCAL1 = 2'd1,
      GRP_MAPPED = 2'd2,
      GRP_NONE   = 2'd3
   } group_type;

   typedef enum logic [2:0] {
      REG_LOCAL0_STATUS = 3'd0,
      REG_LOCAL0_MASK   = 3'd1,
      REG_LOCAL1_STATUS = 3'd2,
      REG_LOCAL1_MASK   = 3'd3,
      REG_MAPPED_STATUS = 3'd4,
      REG_MAPPED_MASK2  = 3'd5,
      REG_MAPPED_MASK3  = 3'd6,
      REG_MAPPED_POL    = 3'd7
   } reg_index_type;

   typedef struct packed {
      op_type      operation;
      logic [31:0] address;
      logic [31:0] write_data;
      group_type   int_group;
      logic [7:0]  int_bits;
   } request_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        line2_pending;
      logic [7:0]  line2_cause;
      logic        line3_pending;
      logic [7:0]  line3_cause;
   } result_type;

endpackage

// File: design/ismc_core.sv
// ismc_core: status, mask and polarity registers with bus decode and line logic.
// Commits one request per cycle when commit is high; result is combinational.
// Depends on ismc_pkg.
`timescale 1ns / 1ps

module ismc_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                commit,
   input  ismc_pkg::request_type req,
   output ismc_pkg::result_type  result
);

   logic [7:0] local0_status_ff, local0_status_in;
   logic [7:0] local0_mask_ff,   local0_mask_in;
   logic [7:0] local1_status_ff, local1_status_in;
   logic [7:0] local1_mask_ff,   local1_mask_in;
   logic [7:0] mapped_status_ff, mapped_status_in;
   logic [7:0] mapped_mask2_ff,  mapped_mask2_in;
   logic [7:0] mapped_mask3_ff,  mapped_mask3_in;
   logic [7:0] mapped_pol_ff,    mapped_pol_in;

   logic [31:0] offset;
   logic        decoded;
   ismc_pkg::reg_index_type index;
   logic [7:0]  read_byte;
   logic [7:0]  wr_byte;
   logic [7:0]  local2, local3;
   logic [7:0]  cause2, cause3;

   // window decode: inside the window, aligned to the stride, index below eight
   assign offset  = req.address - ismc_pkg::WINDOW_BASE;
   assign index   = ismc_pkg::reg_index_type'(offset[ismc_pkg::STRIDE_SHIFT +: 3]);
   assign decoded = (req.address >= ismc_pkg::WINDOW_BASE)
                 && (offset < ismc_pkg::WINDOW_BYTES)
                 && (offset[ismc_pkg::STRIDE_SHIFT-1:0] == '0)
                 && ((offset >> ismc_pkg::STRIDE_SHIFT) < 32'(ismc_pkg::REG_COUNT));
   assign wr_byte = req.write_data[ismc_pkg::BYTE_SHIFT +: 8];

   always_comb begin
      case (index)
         ismc_pkg::REG_LOCAL0_STATUS: read_byte = local0_status_ff;
         ismc_pkg::REG_LOCAL0_MASK:   read_byte = local0_mask_ff;
         ismc_pkg::REG_LOCAL1_STATUS: read_byte = local1_status_ff;
         ismc_pkg::REG_LOCAL1_MASK:   read_byte = local1_mask_ff;
         ismc_pkg::REG_MAPPED_STATUS: read_byte = mapped_status_ff;
         ismc_pkg::REG_MAPPED_MASK2:  read_byte = mapped_mask2_ff;
         ismc_pkg::REG_MAPPED_MASK3:  read_byte = mapped_mask3_ff;
         ismc_pkg::REG_MAPPED_POL:    read_byte = mapped_pol_ff;
         default:                     read_byte = 8'd0;
      endcase
   end

   always_comb begin
      local0_status_in = local0_status_ff;
      local0_mask_in   = local0_mask_ff;
      local1_status_in = local1_status_ff;
      local1_mask_in   = local1_mask_ff;
      mapped_status_in = mapped_status_ff;
      mapped_mask2_in  = mapped_mask2_ff;
      mapped_mask3_in  = mapped_mask3_ff;
      mapped_pol_in    = mapped_pol_ff;
      case (req.operation)
         ismc_pkg::OP_READ: begin
         end
         ismc_pkg::OP_WRITE: begin
            if (decoded) begin
               case (index)
                  ismc_pkg::REG_LOCAL0_MASK:  local0_mask_in  = wr_byte;
                  ismc_pkg::REG_LOCAL1_MASK:  local1_mask_in  = wr_byte;
                  ismc_pkg::REG_MAPPED_MASK2: mapped_mask2_in = wr_byte;
                  ismc_pkg::REG_MAPPED_MASK3: mapped_mask3_in = wr_byte;
                  ismc_pkg::REG_MAPPED_POL:   mapped_pol_in   = wr_byte;
                  default: begin
                  end
               endcase
            end
         end
         ismc_pkg::OP_ASSERT: begin
            case (req.int_group)
               ismc_pkg::GRP_LOCAL0: local0_status_in = local0_status_ff | req.int_bits;
               ismc_pkg::GRP_LOCAL1: local1_status_in = local1_status_ff | req.int_bits;
               ismc_pkg::GRP_MAPPED: mapped_status_in = mapped_status_ff | req.int_bits;
               default: begin
               end
            endcase
         end
         default: begin
            case (req.int_group)
               ismc_pkg::GRP_LOCAL0: local0_status_in = local0_status_ff & ~req.int_bits;
               ismc_pkg::GRP_LOCAL1: local1_status_in = local1_status_ff & ~req.int_bits;
               ismc_pkg::GRP_MAPPED: mapped_status_in = mapped_status_ff & ~req.int_bits;
               default: begin
               end
            endcase
         end
      endcase
   end

   // lines reflect the state after this request; local bits take precedence
   assign local2 = local0_status_in & local0_mask_in;
   assign local3 = local1_status_in & local1_mask_in;
   assign cause2 = (local2 != 8'd0) ? local2
                 : ((mapped_status_in & mapped_mask2_in) != 8'd0)
                   ? ismc_pkg::LINE2_MAPPED_CAUSE : 8'd0;
   assign cause3 = (local3 != 8'd0) ? local3
                 : ((mapped_status_in & mapped_mask3_in) != 8'd0)
                   ? ismc_pkg::LINE3_MAPPED_CAUSE : 8'd0;

   always_comb begin
      result.read_data     = (req.operation == ismc_pkg::OP_READ && decoded)
                           ? {read_byte, 24'd0} : 32'd0;
      result.line2_pending = (cause2 != 8'd0);
      result.line2_cause   = cause2;
      result.line3_pending = (cause3 != 8'd0);
      result.line3_cause   = cause3;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local0_status_ff <= 8'd0;
         local0_mask_ff   <= 8'd0;
         local1_status_ff <= 8'd0;
         local1_mask_ff   <= 8'd0;
         mapped_status_ff <= 8'd0;
         mapped_mask2_ff  <= 8'd0;
         mapped_mask3_ff  <= 8'd0;
         mapped_pol_ff    <= 8'd0;
      end else if (commit) begin
         local0_status_ff <= local0_status_in;
         local0_mask_ff   <= local0_mask_in;
         local1_status_ff <= local1_status_in;
         local1_mask_ff   <= local1_mask_in;
         mapped_status_ff <= mapped_status_in;
         mapped_mask2_ff  <= mapped_mask2_in;
         mapped_mask3_ff  <= mapped_mask3_in;
         mapped_pol_ff    <= mapped_pol_in;
      end
   end

endmodule

// File: design/interrupt_status_mask_controller.sv
// interrupt_status_mask_controller: top level with request and result registers.
// Depends on ismc_pkg and ismc_core.
`timescale 1ns / 1ps

// Usage
//   req_*  : one request per transfer: a bus read, a bus write, or an assert
//            or clear of status bits in one group (kind and group in tuser).
//   rsp_*  : exactly one result per request, in order: read data and the
//            state of interrupt lines 2 and 3 with their cause bytes after
//            the request has been applied.
//   Path:    a request passes through the request register, then the result
//            register; state is committed and rsp_tvalid rises as the
//            request moves into the result register, which it enters only
//            once that register is empty or its result is being taken.
//   Throughput: one request per cycle while rsp_tready holds no result,
//            set by the byte-wide decode and update between the two registers.
//   Stall: while a result waits on rsp_tready one more request is held in
//            the request register; req_tready drops only when both are full.
//   Reset: all status, mask and polarity bytes clear to zero and both
//            registers empty.
module interrupt_status_mask_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // address[31:0], write_data[63:32], int_bits[71:64]
   input  logic [3:0]  req_tuser,  // operation[1:0], int_group[3:2]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata   // read_data[31:0], line2_pending[32], line2_cause[40:33],
                                   // line3_pending[41], line3_cause[49:42], zero[55:50]
);

   logic                  in_valid_ff;
   ismc_pkg::request_type in_ff;
   logic                  out_valid_ff;
   ismc_pkg::result_type  out_ff;
   ismc_pkg::result_type  result;
   logic                  advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   ismc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .commit (advance),
      .req    (in_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_ff.operation  <= ismc_pkg::op_type'(req_tuser[1:0]);
         in_ff.int_group  <= ismc_pkg::group_type'(req_tuser[3:2]);
         in_ff.address    <= req_tdata[31:0];
         in_ff.write_data <= req_tdata[63:32];
         in_ff.int_bits   <= req_tdata[71:64];
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_ff.line3_cause, out_ff.line3_pending,
                        out_ff.line2_cause, out_ff.line2_pending, out_ff.read_data};

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req_tready)
      else $error("request refused with result register empty");

   a_pending_matches_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[32] == (rsp_tdata[40:33] != 8'd0))
                  && (rsp_tdata[41] == (rsp_tdata[49:42] != 8'd0)))
      else $error("line pending disagrees with cause byte");

   a_read_low_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[23:0] == 24'd0) && (rsp_tdata[55:50] == 6'd0))
      else $error("result carries bits outside the register byte");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !in_valid_ff && !out_valid_ff)
      else $error("registers not empty after reset");

endmodule
